// ===== hw/rtl/framed_packet_byte_parser_macros.svh =====
// ----------------------------------------------------------------------------
// framed_packet_byte_parser_macros.svh
// Assertion macros for the framed packet byte parser. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_BYTE_PARSER_MACROS_SVH
`define FRAMED_PACKET_BYTE_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted.
`define FPBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define FPBP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FPBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPBP_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/fpbp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpbp_pkg
// Shared constants and types for the framed packet byte parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fpbp_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 16;

    typedef logic [ByteW-1:0] t_byte;
    typedef logic [WordW-1:0] t_word;

    // Frame delimiters
    localparam t_byte SOF_BYTE      = 8'h3a;
    localparam t_byte EOF_BYTE_CR   = 8'h0d;
    localparam t_byte EOF_BYTE_LF   = 8'h0a;

    // Result event codes
    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_DONE    = 2'd1,
        EV_DROP    = 2'd2
    } t_event;

endpackage

`default_nettype wire

// ===== hw/rtl/framed_packet_byte_parser.sv =====
// ----------------------------------------------------------------------------
// framed_packet_byte_parser
// Byte-wise frame recognizer: 0x3a start, LE address/command/length header,
// payload, LE check word, 0x0d 0x0a end. Emits payload bytes, frame-complete
// and frame-drop results.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, while the output is not stalled.
// Path: an accepted byte passes the input register, then the result register;
//   its result (if any) is shown on the outputs from the result register.
// Reset: i_rst_n synchronous active low; parser returns to hunting for the
//   start byte, held header fields clear, both pipeline registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "framed_packet_byte_parser_macros.svh"

module framed_packet_byte_parser
    import fpbp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // byte input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,

    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_res,
    output logic [15:0]      o_frame_address,
    output logic [15:0]      o_frame_command,
    output logic [15:0]      o_frame_length,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_payload_index,
    output logic [15:0]      o_received_check
);

    // Parse phase; codes 12..15 are unreachable and fall back to hunting.
    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_ADDR_LO = 4'd1,
        PH_ADDR_HI = 4'd2,
        PH_CMD_LO  = 4'd3,
        PH_CMD_HI  = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_LEN_HI  = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CHK_LO  = 4'd8,
        PH_CHK_HI  = 4'd9,
        PH_END_A   = 4'd10,
        PH_END_B   = 4'd11
    } t_phase;

    // Input register stage
    logic   r_in_valid;
    t_byte  r_in_byte;

    // Parser state
    t_phase r_phase,   n_phase;
    t_word  r_address, n_address;
    t_word  r_command, n_command;
    t_word  r_length,  n_length;
    t_word  r_count,   n_count;
    t_word  r_check,   n_check;

    // Result register
    logic   r_out_valid;
    t_event r_event,   n_event;
    t_word  r_out_address;
    t_word  r_out_command;
    t_word  r_out_length;
    t_byte  r_out_byte,  n_out_byte;
    t_word  r_out_index, n_out_index;
    t_word  r_out_check, n_out_check;

    logic   n_has_result;
    logic   out_free;   // result register can take a new value this cycle
    logic   work;       // the held byte is parsed this cycle
    t_word  count_inc;
    t_word  length_full;

    // The result register frees when empty or when its transfer completes.
    // The input register moves whenever the parse stage moves, so a byte
    // is only held back while a finished result waits downstream.
    assign out_free = !r_out_valid || !i_stall;
    assign work     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    assign count_inc   = r_count + 16'd1;
    assign length_full = {r_in_byte, r_length[7:0]};

    // Next-state and result decode for the held byte
    always_comb begin
        n_phase      = r_phase;
        n_address    = r_address;
        n_command    = r_command;
        n_length     = r_length;
        n_count      = r_count;
        n_check      = r_check;
        n_has_result = 1'b0;
        n_event      = EV_PAYLOAD;
        n_out_byte   = '0;
        n_out_index  = '0;
        n_out_check  = '0;

        unique case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == SOF_BYTE) begin
                    n_count = '0;
                    n_phase = PH_ADDR_LO;
                end
            end
            PH_ADDR_LO: begin
                n_address = {8'h00, r_in_byte};
                n_phase   = PH_ADDR_HI;
            end
            PH_ADDR_HI: begin
                n_address = {r_in_byte, r_address[7:0]};
                n_phase   = PH_CMD_LO;
            end
            PH_CMD_LO: begin
                n_command = {8'h00, r_in_byte};
                n_phase   = PH_CMD_HI;
            end
            PH_CMD_HI: begin
                n_command = {r_in_byte, r_command[7:0]};
                n_phase   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {8'h00, r_in_byte};
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = length_full;
                // empty payload skips straight to the check word
                n_phase  = (length_full != '0) ? PH_PAYLOAD : PH_CHK_LO;
            end
            PH_PAYLOAD: begin
                n_has_result = 1'b1;
                n_event      = EV_PAYLOAD;
                n_out_byte   = r_in_byte;
                n_out_index  = r_count;
                if (count_inc == r_length) begin
                    n_count = '0;
                    n_phase = PH_CHK_LO;
                end else begin
                    n_count = count_inc;
                end
            end
            PH_CHK_LO: begin
                n_check = {8'h00, r_in_byte};
                n_phase = PH_CHK_HI;
            end
            PH_CHK_HI: begin
                n_check = {r_in_byte, r_check[7:0]};
                n_phase = PH_END_A;
            end
            PH_END_A: begin
                if (r_in_byte == EOF_BYTE_CR) begin
                    n_phase = PH_END_B;
                end else begin
                    // bad byte is consumed, even if it looks like a start
                    n_has_result = 1'b1;
                    n_event      = EV_DROP;
                    n_out_check  = r_check;
                    n_phase      = PH_HUNT;
                end
            end
            PH_END_B: begin
                n_has_result = 1'b1;
                n_event      = (r_in_byte == EOF_BYTE_LF) ? EV_DONE : EV_DROP;
                n_out_check  = r_check;
                n_phase      = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // State, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HUNT;
            r_address   <= '0;
            r_command   <= '0;
            r_length    <= '0;
            r_count     <= '0;
            r_check     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
                if (i_valid) begin
                    r_in_byte <= i_rx_byte;
                end
            end

            if (out_free) begin
                r_out_valid <= work && n_has_result;
            end

            if (work) begin
                r_phase   <= n_phase;
                r_address <= n_address;
                r_command <= n_command;
                r_length  <= n_length;
                r_count   <= n_count;
                r_check   <= n_check;
                if (n_has_result) begin
                    // header fields hold across payload and end phases
                    r_event       <= n_event;
                    r_out_address <= r_address;
                    r_out_command <= r_command;
                    r_out_length  <= r_length;
                    r_out_byte    <= n_out_byte;
                    r_out_index   <= n_out_index;
                    r_out_check   <= n_out_check;
                end
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_res      = r_event;
    assign o_frame_address  = r_out_address;
    assign o_frame_command  = r_out_command;
    assign o_frame_length   = r_out_length;
    assign o_payload_byte   = r_out_byte;
    assign o_payload_index  = r_out_index;
    assign o_received_check = r_out_check;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `FPBP_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> (!o_valid && r_phase == PH_HUNT && !r_in_valid), "reset did not clear parser")
    `FPBP_ASSERT(a_held_byte_kept, i_clk, i_rst_n, (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_byte)), "held input byte lost while output blocked")
    `FPBP_ASSERT(a_index_in_range, i_clk, i_rst_n, (o_valid && o_event_res == EV_PAYLOAD) |-> (o_payload_index < o_frame_length), "payload index beyond frame length")
    `FPBP_ASSERT(a_end_returns_hunt, i_clk, i_rst_n, (work && r_phase == PH_END_B) |=> (r_phase == PH_HUNT && o_valid), "end pair did not finish frame")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for framed_packet_byte_parser. Byte streams of whole
// frames, damaged frames and line noise go in through the valid/stall byte
// channel. A frame-tracking model in the bench predicts every payload,
// frame-complete and frame-drop event, and each result transfer is checked
// against the oldest predicted event.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import fpbp_pkg::*;

    localparam int unsigned CycleLimit  = 400_000;
    localparam int unsigned RandomBytes = 760;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned MaxReports  = 10;

    // Parser position inside a frame, kept by the bench model.
    typedef enum logic [3:0] {
        FR_HUNT,
        FR_ADDR_LO,
        FR_ADDR_HI,
        FR_CMD_LO,
        FR_CMD_HI,
        FR_LEN_LO,
        FR_LEN_HI,
        FR_PAYLOAD,
        FR_CHK_LO,
        FR_CHK_HI,
        FR_END_CR,
        FR_END_LF
    } t_frame_pos;

    typedef struct packed {
        t_event ev;
        t_word  addr;
        t_word  cmd;
        t_word  len;
        t_byte  data;
        t_word  idx;
        t_word  chk;
    } t_frame_event;

    // Tracks frames byte by byte and keeps the events still owed by the block.
    class frame_tracker;
        t_frame_pos   pos;
        t_word        addr;
        t_word        cmd;
        t_word        len;
        t_word        count;
        t_word        chk;
        t_frame_event pending[$];
        int unsigned  failures;
        int unsigned  consumed;

        function new();
            pos      = FR_HUNT;
            addr     = '0;
            cmd      = '0;
            len      = '0;
            count    = '0;
            chk      = '0;
            failures = 0;
            consumed = 0;
        endfunction

        function void owe(t_event ev, t_byte data, t_word idx, t_word word);
            t_frame_event e;
            e.ev   = ev;
            e.addr = addr;
            e.cmd  = cmd;
            e.len  = len;
            e.data = data;
            e.idx  = idx;
            e.chk  = word;
            pending.push_back(e);
        endfunction

        // Called once per accepted input transfer.
        function void parse_byte(t_byte b);
            if (pos != FR_HUNT || b == SOF_BYTE)
                consumed++;
            case (pos)
                FR_HUNT: begin
                    if (b == SOF_BYTE) begin
                        count = '0;
                        pos   = FR_ADDR_LO;
                    end
                end
                FR_ADDR_LO: begin
                    addr = {8'h00, b};
                    pos  = FR_ADDR_HI;
                end
                FR_ADDR_HI: begin
                    addr[15:8] = b;
                    pos        = FR_CMD_LO;
                end
                FR_CMD_LO: begin
                    cmd = {8'h00, b};
                    pos = FR_CMD_HI;
                end
                FR_CMD_HI: begin
                    cmd[15:8] = b;
                    pos       = FR_LEN_LO;
                end
                FR_LEN_LO: begin
                    len = {8'h00, b};
                    pos = FR_LEN_HI;
                end
                FR_LEN_HI: begin
                    len[15:8] = b;
                    pos       = (len != '0) ? FR_PAYLOAD : FR_CHK_LO;
                end
                FR_PAYLOAD: begin
                    owe(EV_PAYLOAD, b, count, '0);
                    count = count + 16'd1;
                    if (count == len) begin
                        count = '0;
                        pos   = FR_CHK_LO;
                    end
                end
                FR_CHK_LO: begin
                    chk = {8'h00, b};
                    pos = FR_CHK_HI;
                end
                FR_CHK_HI: begin
                    chk[15:8] = b;
                    pos       = FR_END_CR;
                end
                FR_END_CR: begin
                    if (b == EOF_BYTE_CR) begin
                        pos = FR_END_LF;
                    end else begin
                        owe(EV_DROP, '0, '0, chk);
                        pos = FR_HUNT;
                    end
                end
                FR_END_LF: begin
                    owe((b == EOF_BYTE_LF) ? EV_DONE : EV_DROP, '0, '0, chk);
                    pos = FR_HUNT;
                end
                default: pos = FR_HUNT;
            endcase
        endfunction

        function string show(t_frame_event e);
            return $sformatf("ev=%0d addr=%h cmd=%h len=%h byte=%h idx=%h chk=%h",
                             e.ev, e.addr, e.cmd, e.len, e.data, e.idx, e.chk);
        endfunction

        // Called once per accepted result transfer.
        function void check_result(t_frame_event got);
            t_frame_event want;
            bit           bad;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= MaxReports)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = pending.pop_front();
            bad  = (got.ev   != want.ev)   || (got.addr != want.addr) ||
                   (got.cmd  != want.cmd)  || (got.len  != want.len)  ||
                   (got.data != want.data) || (got.idx  != want.idx)  ||
                   (got.chk  != want.chk);
            if (bad) begin
                failures++;
                if (failures <= MaxReports)
                    $display("mismatch: expected %s, got %s", show(want), show(got));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_event_res;
    logic [15:0] o_frame_address;
    logic [15:0] o_frame_command;
    logic [15:0] o_frame_length;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_payload_index;
    logic [15:0] o_received_check;

    frame_tracker tracker;

    // Idle rates in percent; the stimulus process moves them between phases.
    int unsigned gap_pct   = 9;
    int unsigned stall_pct = 62;
    int unsigned cycles    = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    framed_packet_byte_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_res      (o_event_res),
        .o_frame_address  (o_frame_address),
        .o_frame_command  (o_frame_command),
        .o_frame_length   (o_frame_length),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_received_check (o_received_check)
    );

    // Watchdog: a hung handshake must not run forever.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: sample on the edge (pre-update values), then pick the
    // stall for the next cycle. Only one NBA to i_stall per edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_event got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.ev   = t_event'(o_event_res);
            got.addr = o_frame_address;
            got.cmd  = o_frame_command;
            got.len  = o_frame_length;
            got.data = o_payload_byte;
            got.idx  = o_payload_index;
            got.chk  = o_received_check;
            tracker.check_result(got);
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Byte side. Every task is entered just after the rising clock and returns
    // just after the rising clock at which its last byte transfer took place.
    // ------------------------------------------------------------------------
    task automatic send_byte(input t_byte b);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        // o_stall read here is the value the block saw at this edge
        do @(posedge i_clk); while (o_stall);
        tracker.parse_byte(b);
    endtask

    task automatic send_word(input t_word w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
    endtask

    // fill < 0 gives random payload bytes, otherwise every byte is fill.
    // The second end byte is only sent when the first one is the right one;
    // after a bad first end byte the parser is already hunting again.
    task automatic send_frame(input t_word addr, input t_word cmd, input t_word len,
                              input int fill, input t_word chk,
                              input t_byte end_cr, input t_byte end_lf);
        send_byte(SOF_BYTE);
        send_word(addr);
        send_word(cmd);
        send_word(len);
        for (int unsigned k = 0; k < len; k++)
            send_byte((fill < 0) ? t_byte'($urandom_range(255)) : t_byte'(fill));
        send_word(chk);
        send_byte(end_cr);
        if (end_cr == EOF_BYTE_CR)
            send_byte(end_lf);
    endtask

    // Line noise; never a start byte, so it stays outside any frame.
    task automatic send_noise(input int unsigned n);
        t_byte b;
        for (int unsigned k = 0; k < n; k++) begin
            do b = t_byte'($urandom_range(255)); while (b == SOF_BYTE);
            send_byte(b);
        end
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        t_word       len;
        t_byte       cr;
        t_byte       lf;
        pick = $urandom_range(99);
        // mostly short payloads, a few longer ones
        if (pick < 40)
            len = t_word'($urandom_range(3));
        else if (pick < 85)
            len = t_word'($urandom_range(16, 4));
        else
            len = t_word'($urandom_range(64, 17));
        cr   = EOF_BYTE_CR;
        lf   = EOF_BYTE_LF;
        pick = $urandom_range(99);
        if (pick < 7) begin
            // damaged first end byte, sometimes a start byte
            if ($urandom_range(3) == 0)
                cr = SOF_BYTE;
            else
                do cr = t_byte'($urandom_range(255)); while (cr == EOF_BYTE_CR);
        end else if (pick < 14) begin
            do lf = t_byte'($urandom_range(255)); while (lf == EOF_BYTE_LF);
        end
        send_frame(t_word'($urandom_range(65535)), t_word'($urandom_range(65535)),
                   len, -1, t_word'($urandom_range(65535)), cr, lf);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned pick;
        tracker = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero header with zero length (no payload events),
        // preceded by a bit of noise that must be ignored.
        send_noise(2);
        send_frame(16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, EOF_BYTE_CR, EOF_BYTE_LF);
        // All-ones address, start bytes inside header, payload and check word,
        // and a start byte as bad first end byte: drop, and that byte must not
        // open a new frame, so the two bytes after it are ignored.
        send_frame(16'hffff, 16'h3a3a, 16'h0002, 8'h3a, 16'h3a3a, SOF_BYTE, EOF_BYTE_LF);
        send_noise(2);
        // Good first end byte, bad second end byte: drop.
        send_frame(16'h8001, 16'hffff, 16'h0001, 8'hff, 16'hffff, EOF_BYTE_CR, EOF_BYTE_CR);

        // Random: mostly frames with random content, some damaged ends,
        // some noise. Idle mix changes by thirds.
        while (tracker.consumed < RandomBytes) begin
            if (tracker.consumed >= 2 * RandomBytes / 3) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (tracker.consumed >= RandomBytes / 3) begin
                gap_pct   = 62;
                stall_pct = 9;
            end
            pick = $urandom_range(99);
            if (pick < 88)
                send_random_frame();
            else
                send_noise($urandom_range(6, 1));
        end

        // One frame with a nonzero upper length byte: covers the upper length
        // bits and payload indexes past one byte. Sent without idling.
        send_frame(t_word'($urandom_range(65535)), t_word'($urandom_range(65535)),
                   16'h0104, -1, t_word'($urandom_range(65535)), EOF_BYTE_CR, EOF_BYTE_LF);
        i_valid <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
